// ===== rtl/assert_macros.svh =====
// Assertion macros for the quad warp RTL; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond at an edge requires expr at the same edge
`define QA_HOLDS(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// cond at an edge requires expr at the next edge
`define QA_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== rtl/qcpw_pkg.sv =====
// Shared types, constants and helpers for the quad corner pixel warp.
`timescale 1ns / 1ps
package qcpw_pkg;

  localparam int SIZE_W     = 13;
  localparam int POS_W      = 13;
  localparam int CORNER_W   = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int SLOPE_W    = 32;
  localparam int FRAC       = 17;
  localparam int DELTA_W    = 17;
  localparam int DELTA_SH   = 18;
  localparam int SIZE_MAX   = (1 << SIZE_W) - 1;

  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TL_CORNER     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TR_CORNER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BL_CORNER     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BR_CORNER     = 3'd5;

  localparam int JOB_W = 3;
  localparam logic [JOB_W-1:0] JOB_TOP_X = 3'd0;
  localparam logic [JOB_W-1:0] JOB_TOP_Y = 3'd1;
  localparam logic [JOB_W-1:0] JOB_BOT_X = 3'd2;
  localparam logic [JOB_W-1:0] JOB_BOT_Y = 3'd3;
  localparam logic [JOB_W-1:0] JOB_RECIP = 3'd4;

  localparam int DIV_STEPS = 33;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // datapath widths
  localparam int PW    = SLOPE_W + POS_W + 1;
  localparam int SH_W  = DELTA_W + DELTA_SH;
  localparam int BW    = PW + 1;
  localparam int DW    = BW + 1;
  localparam int TW    = DW + POS_W;
  localparam int QW    = TW;
  localparam int TMW   = QW + 1;
  localparam int XQW   = TMW + 1;
  localparam int XW    = XQW - FRAC;

  typedef enum logic [1:0] {
    DRV_LOAD,
    DRV_DIV,
    DRV_STORE,
    DRV_DONE
  } drv_state_t;

  typedef struct packed {
    logic [SLOPE_W-1:0] top_x;
    logic [SLOPE_W-1:0] top_y;
    logic [SLOPE_W-1:0] bot_x;
    logic [SLOPE_W-1:0] bot_y;
    logic [31:0]        recip;
  } coef_t;

  function automatic logic signed [DELTA_W-1:0] ext17(input logic [15:0] v);
    return $signed({v[15], v});
  endfunction

endpackage

// ===== rtl/qcpw_coef_gen.sv =====
// Edge slope and height reciprocal derivation through one shared radix-2 divider.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qcpw_coef_gen (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             restart,
  input  logic [qcpw_pkg::SIZE_W-1:0]      w_eff,
  input  logic [qcpw_pkg::SIZE_W-1:0]      h_eff,
  input  logic [qcpw_pkg::CORNER_W-1:0]    tl,
  input  logic [qcpw_pkg::CORNER_W-1:0]    tr,
  input  logic [qcpw_pkg::CORNER_W-1:0]    bl,
  input  logic [qcpw_pkg::CORNER_W-1:0]    br,
  output qcpw_pkg::coef_t                  coef,
  output logic                             ready
);

  localparam logic [qcpw_pkg::CNT_W-1:0] LAST = qcpw_pkg::CNT_W'(qcpw_pkg::DIV_STEPS - 1);
  localparam int SW = qcpw_pkg::SIZE_W;
  localparam int QDW = qcpw_pkg::DIV_STEPS;

  qcpw_pkg::drv_state_t state_r, state_nxt;
  logic [qcpw_pkg::JOB_W-1:0] job_r;
  logic [qcpw_pkg::CNT_W-1:0] cnt_r;
  logic [SW-1:0]              rem_r;
  logic [QDW-1:0]             quo_r;
  logic [SW-1:0]              dvs_r;
  logic                       neg_r;
  qcpw_pkg::coef_t            coef_r;

  logic do_load, do_step, do_store;
  logic [SW-1:0] sw;
  logic signed [qcpw_pkg::DELTA_W-1:0] delta;
  logic [qcpw_pkg::DELTA_W-1:0] dmag;
  logic [SW-1:0]  dvs_sel;
  logic [QDW-1:0] dvd_sel;
  logic [SW:0]    trial;
  logic           ge;
  logic [31:0]    res;

  assign sw = w_eff - SW'({w_eff[SW-1:2], 1'b0});

  always_comb begin
    unique case (job_r)
      qcpw_pkg::JOB_TOP_X: delta = qcpw_pkg::ext17(tr[15:0]) - qcpw_pkg::ext17(tl[15:0]);
      qcpw_pkg::JOB_TOP_Y: delta = qcpw_pkg::ext17(tr[31:16]) - qcpw_pkg::ext17(tl[31:16]);
      qcpw_pkg::JOB_BOT_X: delta = qcpw_pkg::ext17(br[15:0]) - qcpw_pkg::ext17(bl[15:0]);
      qcpw_pkg::JOB_BOT_Y: delta = qcpw_pkg::ext17(br[31:16]) - qcpw_pkg::ext17(bl[31:16]);
      default:             delta = '0;
    endcase
    dmag = delta[qcpw_pkg::DELTA_W-1] ? qcpw_pkg::DELTA_W'(-delta) : qcpw_pkg::DELTA_W'(delta);
    if (job_r == qcpw_pkg::JOB_RECIP) begin
      dvs_sel = h_eff;
      dvd_sel = {1'b1, 32'b0} + QDW'(h_eff) - QDW'(1);
    end else begin
      dvs_sel = sw;
      dvd_sel = {1'b0, dmag[15:0], 16'b0};
    end
  end

  always_comb begin
    trial = {rem_r, quo_r[QDW-1]};
    ge    = trial >= {1'b0, dvs_r};
  end

  always_comb begin
    if (dvs_r == '0) begin
      res = '0;
    end else if (job_r == qcpw_pkg::JOB_RECIP) begin
      res = quo_r[QDW-1] ? 32'hFFFF_FFFF : quo_r[31:0];
    end else if (neg_r) begin
      res = (quo_r > 33'h0_8000_0000) ? 32'h8000_0000 : 32'd0 - quo_r[31:0];
    end else begin
      res = (quo_r > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : quo_r[31:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qcpw_pkg::DRV_LOAD:  state_nxt = qcpw_pkg::DRV_DIV;
      qcpw_pkg::DRV_DIV:   state_nxt = (cnt_r == LAST) ? qcpw_pkg::DRV_STORE : qcpw_pkg::DRV_DIV;
      qcpw_pkg::DRV_STORE: state_nxt = (job_r == qcpw_pkg::JOB_RECIP) ? qcpw_pkg::DRV_DONE
                                                                      : qcpw_pkg::DRV_LOAD;
      qcpw_pkg::DRV_DONE:  state_nxt = qcpw_pkg::DRV_DONE;
      default:             state_nxt = qcpw_pkg::DRV_LOAD;
    endcase
    if (restart) begin
      state_nxt = qcpw_pkg::DRV_LOAD;
    end
  end

  always_comb begin
    do_load  = 1'b0;
    do_step  = 1'b0;
    do_store = 1'b0;
    ready    = 1'b0;
    unique case (state_r)
      qcpw_pkg::DRV_LOAD:  do_load  = 1'b1;
      qcpw_pkg::DRV_DIV:   do_step  = 1'b1;
      qcpw_pkg::DRV_STORE: do_store = 1'b1;
      qcpw_pkg::DRV_DONE:  ready    = 1'b1;
      default:             ready    = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qcpw_pkg::DRV_LOAD;
      job_r   <= qcpw_pkg::JOB_TOP_X;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (restart) begin
        job_r <= qcpw_pkg::JOB_TOP_X;
      end else if (do_store) begin
        job_r <= job_r + qcpw_pkg::JOB_W'(1);
      end
      if (do_load) begin
        cnt_r <= '0;
      end else if (do_step) begin
        cnt_r <= cnt_r + qcpw_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      rem_r <= '0;
      quo_r <= dvd_sel;
      dvs_r <= dvs_sel;
      neg_r <= delta[qcpw_pkg::DELTA_W-1];
    end else if (do_step) begin
      rem_r <= ge ? SW'(trial - {1'b0, dvs_r}) : trial[SW-1:0];
      quo_r <= {quo_r[QDW-2:0], ge};
    end
    if (do_store) begin
      case (job_r)
        qcpw_pkg::JOB_TOP_X: coef_r.top_x <= res;
        qcpw_pkg::JOB_TOP_Y: coef_r.top_y <= res;
        qcpw_pkg::JOB_BOT_X: coef_r.bot_x <= res;
        qcpw_pkg::JOB_BOT_Y: coef_r.bot_y <= res;
        default:             coef_r.recip <= res;
      endcase
    end
  end

  assign coef = coef_r;

  `QA_HOLDS(a_recip_set, ready && (h_eff != '0), coef_r.recip != '0, "zero reciprocal for nonzero height")
  `QA_HOLDS(a_flat_square, ready && (sw == '0), (coef_r.top_x == '0) && (coef_r.bot_y == '0), "slope not zero for empty square")

endmodule

// ===== rtl/quad_corner_pixel_warp.sv =====
// Quad corner pixel warp top level: config registers and the forward mapping pipeline.
// An accepted request passes through pipeline stages 0-9 and the output register to out_*.
// Throughput: one request per clock while in_stall is low, set by the ten-stage multiply/add pipeline.
// Reset (synchronous, rst_n low) and every write to register indices 0-5 start coefficient
// derivation in the shared radix-2 divider: 5 divides, with in_stall high until they finish.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module quad_corner_pixel_warp #(
  parameter int MAX_CANVAS = 4096,
  parameter int COORD_BITS = 16,
  parameter int PIXEL_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [qcpw_pkg::POS_W-1:0]           in_source_col_half,
  input  logic [qcpw_pkg::POS_W-1:0]           in_source_row_half,
  input  logic [31:0]                          in_source_pixel,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [COORD_BITS-1:0]         out_dest_col,
  output logic signed [COORD_BITS-1:0]         out_dest_row,
  output logic [PIXEL_BITS-1:0]                out_dest_pixel,
  output logic                                 out_inside_canvas,
  input  logic                                 cfg_wr_en,
  input  logic [qcpw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qcpw_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int NST = 10;
  localparam int SW  = qcpw_pkg::SIZE_W;
  localparam int PW  = qcpw_pkg::PW;
  localparam int BW  = qcpw_pkg::BW;
  localparam int DW  = qcpw_pkg::DW;
  localparam int TW  = qcpw_pkg::TW;
  localparam int QW  = qcpw_pkg::QW;
  localparam int TMW = qcpw_pkg::TMW;
  localparam int XQW = qcpw_pkg::XQW;
  localparam int XW  = qcpw_pkg::XW;
  localparam int FR  = qcpw_pkg::FRAC;
  localparam logic [SW-1:0] MAXC =
    SW'((MAX_CANVAS > qcpw_pkg::SIZE_MAX) ? qcpw_pkg::SIZE_MAX : MAX_CANVAS);
  localparam logic signed [XW-1:0] CHI = XW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] CLO = ~CHI;

  // configuration registers
  logic [SW-1:0] w_r, h_r;
  logic [qcpw_pkg::CORNER_W-1:0] tl_r, tr_r, bl_r, br_r;
  logic [SW-1:0] w_eff, h_eff;
  logic cfg_hit;

  qcpw_pkg::coef_t coef;
  logic coef_ready;

  // pipeline control
  logic [NST-1:0] v_r;
  logic [NST:0]   adv;
  logic           in_accept;
  logic           out_valid_r;

  // per-lane constants: lane 0 is x, lane 1 is y
  logic signed [qcpw_pkg::SLOPE_W-1:0] s_top [2];
  logic signed [qcpw_pkg::SLOPE_W-1:0] s_bot [2];
  logic signed [qcpw_pkg::SH_W-1:0]    dbt_sh [2];
  logic signed [qcpw_pkg::SH_W-1:0]    off_sh [2];
  logic [SW-1:0]                       dim [2];
  logic signed [qcpw_pkg::POS_W:0]     col_s;

  // stage registers
  logic [qcpw_pkg::POS_W-1:0] row_r [4];
  logic [PIXEL_BITS-1:0]      pix_r [NST];
  logic signed [PW-1:0]  ax0_r [2];
  logic signed [PW-1:0]  pb0_r [2];
  logic signed [PW-1:0]  ax1_r [2];
  logic signed [BW-1:0]  bx1_r [2];
  logic signed [BW-1:0]  axo_r [1:7][2];
  logic signed [DW-1:0]  diff2_r [2];
  logic                  neg_r [3:6][2];
  logic [DW-1:0]         mag3_r [2];
  logic [TW-1:0]         t4_r [2];
  logic [TW-1:0]         ph5_r [2];
  logic [31:0]           pl5_r [2];
  logic [QW-1:0]         q6_r [2];
  logic signed [TMW-1:0] term7_r [2];
  logic signed [XQW-1:0] xq8_r [2];
  logic signed [XW-1:0]  x9_r [2];

  logic [63:0]           pl_full [2];
  logic [QW:0]           psum [2];
  logic [XQW-1:0]        tsum [2];
  logic [COORD_BITS-1:0] sat [2];
  logic                  in_dim [2];

  logic signed [COORD_BITS-1:0] col_r, row_out_r;
  logic [PIXEL_BITS-1:0]        pixel_r;
  logic                         inside_r;

  assign w_eff = (w_r > MAXC) ? MAXC : w_r;
  assign h_eff = (h_r > MAXC) ? MAXC : h_r;
  assign cfg_hit = cfg_wr_en && (cfg_index <= qcpw_pkg::REG_BR_CORNER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r  <= SW'(640);
      h_r  <= SW'(480);
      tl_r <= 32'd7864480;
      tr_r <= 32'd7864800;
      bl_r <= 32'd23593120;
      br_r <= 32'd23593440;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        qcpw_pkg::REG_CANVAS_WIDTH:  w_r  <= cfg_data[SW-1:0];
        qcpw_pkg::REG_CANVAS_HEIGHT: h_r  <= cfg_data[SW-1:0];
        qcpw_pkg::REG_TL_CORNER:     tl_r <= cfg_data;
        qcpw_pkg::REG_TR_CORNER:     tr_r <= cfg_data;
        qcpw_pkg::REG_BL_CORNER:     bl_r <= cfg_data;
        qcpw_pkg::REG_BR_CORNER:     br_r <= cfg_data;
        default: ;
      endcase
    end
  end

  qcpw_coef_gen u_coef (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_hit),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .tl      (tl_r),
    .tr      (tr_r),
    .bl      (bl_r),
    .br      (br_r),
    .coef    (coef),
    .ready   (coef_ready)
  );

  always_comb begin
    s_top[0]  = $signed(coef.top_x);
    s_top[1]  = $signed(coef.top_y);
    s_bot[0]  = $signed(coef.bot_x);
    s_bot[1]  = $signed(coef.bot_y);
    dbt_sh[0] = $signed({qcpw_pkg::ext17(bl_r[15:0]) - qcpw_pkg::ext17(tl_r[15:0]),
                         qcpw_pkg::DELTA_SH'(0)});
    dbt_sh[1] = $signed({qcpw_pkg::ext17(bl_r[31:16]) - qcpw_pkg::ext17(tl_r[31:16]),
                         qcpw_pkg::DELTA_SH'(0)});
    off_sh[0] = $signed({$signed({6'b0, w_eff[SW-1:2]}) - qcpw_pkg::ext17(tl_r[15:0]),
                         qcpw_pkg::DELTA_SH'(0)});
    off_sh[1] = $signed({$signed({6'b0, h_eff[SW-1:2]}) - qcpw_pkg::ext17(tl_r[31:16]),
                         qcpw_pkg::DELTA_SH'(0)});
    dim[0]    = w_eff;
    dim[1]    = h_eff;
    col_s     = $signed({1'b0, in_source_col_half});
  end

  // advance a stage when it is empty or the one after it advances
  always_comb begin
    adv[NST] = !out_valid_r || !out_stall;
    for (int k = NST - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0] || !coef_ready || cfg_wr_en;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_accept;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (adv[NST]) begin
        out_valid_r <= v_r[NST-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      pl_full[l] = t4_r[l][31:0] * coef.recip;
      psum[l]    = ph5_r[l] + (QW + 1)'(pl5_r[l]);
      tsum[l]    = xq8_r[l] + XQW'({FR{xq8_r[l][XQW-1]}});
      if (x9_r[l] > CHI) begin
        sat[l] = CHI[COORD_BITS-1:0];
      end else if (x9_r[l] < CLO) begin
        sat[l] = CLO[COORD_BITS-1:0];
      end else begin
        sat[l] = x9_r[l][COORD_BITS-1:0];
      end
      in_dim[l] = !x9_r[l][XW-1] && (x9_r[l] < $signed(XW'(dim[l])));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      row_r[0] <= in_source_row_half;
      pix_r[0] <= in_source_pixel[PIXEL_BITS-1:0];
      for (int l = 0; l < 2; l++) begin
        ax0_r[l] <= s_top[l] * col_s;
        pb0_r[l] <= s_bot[l] * col_s;
      end
    end
    for (int k = 1; k < 4; k++) begin
      if (adv[k]) begin
        row_r[k] <= row_r[k-1];
      end
    end
    for (int k = 1; k < NST; k++) begin
      if (adv[k]) begin
        pix_r[k] <= pix_r[k-1];
      end
    end
    for (int k = 2; k < 8; k++) begin
      if (adv[k]) begin
        axo_r[k] <= axo_r[k-1];
      end
    end
    for (int k = 4; k < 7; k++) begin
      if (adv[k]) begin
        neg_r[k] <= neg_r[k-1];
      end
    end
    for (int l = 0; l < 2; l++) begin
      if (adv[1]) begin
        ax1_r[l]    <= ax0_r[l];
        bx1_r[l]    <= pb0_r[l] + dbt_sh[l];
        axo_r[1][l] <= ax0_r[l] - off_sh[l];
      end
      if (adv[2]) begin
        diff2_r[l] <= bx1_r[l] - ax1_r[l];
      end
      if (adv[3]) begin
        neg_r[3][l] <= diff2_r[l][DW-1];
        mag3_r[l]   <= diff2_r[l][DW-1] ? DW'(-diff2_r[l]) : DW'(diff2_r[l]);
      end
      if (adv[4]) begin
        t4_r[l] <= mag3_r[l] * row_r[3];
      end
      if (adv[5]) begin
        ph5_r[l] <= t4_r[l][TW-1:32] * coef.recip;
        pl5_r[l] <= pl_full[l][63:32];
      end
      if (adv[6]) begin
        q6_r[l] <= psum[l][QW:1];
      end
      if (adv[7]) begin
        term7_r[l] <= neg_r[6][l] ? -$signed({1'b0, q6_r[l]}) : $signed({1'b0, q6_r[l]});
      end
      if (adv[8]) begin
        xq8_r[l] <= axo_r[7][l] + term7_r[l];
      end
      if (adv[9]) begin
        x9_r[l] <= $signed(tsum[l][XQW-1:FR]);
      end
    end
    if (adv[NST]) begin
      col_r     <= sat[0];
      row_out_r <= sat[1];
      pixel_r   <= pix_r[NST-1];
      inside_r  <= in_dim[0] && in_dim[1];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_dest_col      = col_r;
  assign out_dest_row      = row_out_r;
  assign out_dest_pixel    = pixel_r;
  assign out_inside_canvas = inside_r;

  `QA_NEXT(a_cfg_restart, cfg_hit, !coef_ready, "register write did not restart derivation")
  `QA_HOLDS(a_inside_nonneg, out_valid && out_inside_canvas, !out_dest_col[COORD_BITS-1] && !out_dest_row[COORD_BITS-1], "inside flag with negative destination")
  `QA_NEXT(a_stage_flow, v_r[0] && adv[1], v_r[1], "request lost between first stages")

endmodule
